@@ src/iposi_pkg.sv @@
// Shared types and constants for the IPv4 option rewrite unit.
// No dependencies; used by the front, queue, back and top level files.
package iposi_pkg;

  localparam logic [7:0] OPT_EOL   = 8'd0;
  localparam logic [7:0] OPT_NOP   = 8'd1;
  localparam logic [7:0] OPT_BSO   = 8'd130;
  localparam logic [7:0] OPT_ESO   = 8'd133;
  localparam logic [7:0] OPT_CIPSO = 8'd134;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LEN  = 2'd1;
  localparam logic [1:0] ERR_SIZE = 2'd2;

  localparam logic [5:0] CNT_MAX = 6'd63;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // One queue entry: a byte to emit, plus trailing pad count and end-of-header info
  typedef struct packed {
    logic [7:0]        data_byte;
    logic [1:0]        pad;
    logic              final_item;
    logic [3:0]        header_words;
    logic signed [6:0] length_change;
    logic [1:0]        error_code;
  } cmd_t;

endpackage

@@ src/iposi_front.sv @@
// Front part: accepts option bytes, runs the option parser and the counters,
// and pushes one command per emitting item. Depends on iposi_pkg.
module iposi_front #(
  parameter int unsigned MAX_OPTION_BYTES = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           op_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_i,
  output logic           push_o,
  output iposi_pkg::cmd_t push_cmd_o
);

  localparam logic [7:0] MaxBytes = 8'(MAX_OPTION_BYTES);

  logic [5:0] left_q, left_d;
  logic       await_q, await_d;
  logic       drop_q, drop_d;
  logic       stop_q, stop_d;
  logic [5:0] old_q, old_d;
  logic [5:0] new_q, new_d;
  logic [1:0] err_q, err_d;

  logic [5:0] old_sat, new_sat;
  logic       emit;
  logic       is_sec;
  logic [1:0] err_c;
  logic [1:0] pad;
  logic [6:0] total;
  logic [4:0] words_w;
  logic [7:0] diff;
  logic       final_item;
  logic [3:0] words;
  logic [6:0] change;

  assign old_sat = (old_q == iposi_pkg::CNT_MAX) ? old_q : old_q + 6'd1;
  assign new_sat = (new_q == iposi_pkg::CNT_MAX) ? new_q : new_q + 6'd1;
  assign is_sec  = (data_byte_i == iposi_pkg::OPT_BSO) || (data_byte_i == iposi_pkg::OPT_ESO) ||
                   (data_byte_i == iposi_pkg::OPT_CIPSO);

  always_comb begin
    left_d     = left_q;
    await_d    = await_q;
    drop_d     = drop_q;
    stop_d     = stop_q;
    old_d      = old_q;
    new_d      = new_q;
    err_c      = err_q;
    emit       = 1'b0;
    final_item = 1'b0;
    pad        = 2'd0;
    total      = 7'd0;
    words_w    = 5'd0;
    diff       = 8'd0;
    words      = 4'd0;
    change     = 7'd0;
    if (!op_i) begin
      old_d = old_sat;
      if ({2'b00, old_sat} > MaxBytes && err_c == iposi_pkg::ERR_NONE) err_c = iposi_pkg::ERR_SIZE;
      if (!stop_q) begin
        if (await_q) begin
          await_d = 1'b0;
          if (data_byte_i < 8'd2 || data_byte_i > MaxBytes) begin
            if (err_c == iposi_pkg::ERR_NONE) err_c = iposi_pkg::ERR_LEN;
            stop_d  = 1'b1;
            drop_d  = 1'b0;
            left_d  = 6'd0;
          end else begin
            left_d = data_byte_i[5:0] - 6'd2;
            emit   = !drop_q;
          end
        end else if (left_q != 6'd0) begin
          left_d = left_q - 6'd1;
          emit   = !drop_q;
        end else if (data_byte_i == iposi_pkg::OPT_EOL) begin
          stop_d = 1'b1;
          drop_d = 1'b0;
        end else if (data_byte_i != iposi_pkg::OPT_NOP) begin
          await_d = 1'b1;
          drop_d  = is_sec;
          emit    = !is_sec;
        end
        if (emit) begin
          new_d = new_sat;
          if ({2'b00, new_sat} > MaxBytes && err_c == iposi_pkg::ERR_NONE)
            err_c = iposi_pkg::ERR_SIZE;
        end
        // option left open at the end of the original run
        if (last_i && (await_d || left_d != 6'd0)) begin
          if (err_c == iposi_pkg::ERR_NONE) err_c = iposi_pkg::ERR_LEN;
          stop_d  = 1'b1;
          await_d = 1'b0;
          drop_d  = 1'b0;
          left_d  = 6'd0;
        end
      end
    end else begin
      emit  = 1'b1;
      new_d = new_sat;
      if ({2'b00, new_sat} > MaxBytes && err_c == iposi_pkg::ERR_NONE) err_c = iposi_pkg::ERR_SIZE;
      if (last_i) begin
        if (!stop_q && (await_q || left_q != 6'd0) && err_c == iposi_pkg::ERR_NONE)
          err_c = iposi_pkg::ERR_LEN;
        pad   = 2'(~new_sat[1:0] + 2'd1);
        total = {1'b0, new_sat} + {5'd0, pad};
        if ({1'b0, total} > MaxBytes && err_c == iposi_pkg::ERR_NONE) err_c = iposi_pkg::ERR_SIZE;
        words_w    = 5'd5 + total[6:2];
        words      = (words_w > 5'd15) ? 4'd15 : words_w[3:0];
        diff       = {1'b0, total} - {2'b00, old_q};
        change     = ($signed(diff) > 8'sd63) ? 7'd63 : diff[6:0];
        final_item = 1'b1;
        // header done: back to reset state
        left_d  = 6'd0;
        await_d = 1'b0;
        drop_d  = 1'b0;
        stop_d  = 1'b0;
        old_d   = 6'd0;
        new_d   = 6'd0;
      end
    end
    err_d = final_item ? iposi_pkg::ERR_NONE : err_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= 6'd0;
      await_q <= 1'b0;
      drop_q  <= 1'b0;
      stop_q  <= 1'b0;
      old_q   <= 6'd0;
      new_q   <= 6'd0;
      err_q   <= iposi_pkg::ERR_NONE;
    end else if (accept_i) begin
      left_q  <= left_d;
      await_q <= await_d;
      drop_q  <= drop_d;
      stop_q  <= stop_d;
      old_q   <= old_d;
      new_q   <= new_d;
      err_q   <= err_d;
    end
  end

  assign push_o                   = accept_i && emit;
  assign push_cmd_o.data_byte     = data_byte_i;
  assign push_cmd_o.pad           = pad;
  assign push_cmd_o.final_item    = final_item;
  assign push_cmd_o.header_words  = words;
  assign push_cmd_o.length_change = change;
  assign push_cmd_o.error_code    = final_item ? err_c : iposi_pkg::ERR_NONE;

endmodule

@@ src/iposi_queue.sv @@
// Short command queue between the parser front and the output back.
// Depends on iposi_pkg for the entry type and depth.
module iposi_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  iposi_pkg::cmd_t push_cmd_i,
  input  logic            pop_i,
  output iposi_pkg::cmd_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  iposi_pkg::cmd_t entries_q [iposi_pkg::QUEUE_DEPTH];

  logic [iposi_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [iposi_pkg::QPTR_W:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (iposi_pkg::QPTR_W+1)'(iposi_pkg::QUEUE_DEPTH));
  assign head_o  = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ src/iposi_back.sv @@
// Back part: expands each queued command into its byte and any EOL padding,
// and holds the result in an output register. Depends on iposi_pkg.
module iposi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iposi_pkg::cmd_t   head_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic              end_of_header_o,
  output logic [3:0]        header_words_o,
  output logic signed [6:0] length_change_o,
  output logic [1:0]        error_code_o
);

  logic [1:0] sub_q, sub_d;
  logic       valid_q;
  logic       load;
  logic       last_sub;
  logic       at_end;

  assign load     = !empty_i && (!valid_q || !out_stall_i);
  assign last_sub = (sub_q == head_i.pad);
  assign at_end   = last_sub && head_i.final_item;
  assign pop_o    = load && last_sub;
  assign sub_d    = last_sub ? 2'd0 : sub_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sub_q   <= sub_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      // first sub-step carries the item byte, the rest are EOL pad
      out_byte_o      <= (sub_q == 2'd0) ? head_i.data_byte : iposi_pkg::OPT_EOL;
      end_of_header_o <= at_end;
      header_words_o  <= at_end ? head_i.header_words : 4'd0;
      length_change_o <= at_end ? head_i.length_change : 7'sd0;
      error_code_o    <= at_end ? head_i.error_code : iposi_pkg::ERR_NONE;
    end
  end

  assign out_valid_o = valid_q;

endmodule

@@ src/ip_option_strip_and_insert_unit.sv @@
// Top level of the IPv4 option rewrite unit: parser front, command queue, output back.
// Depends on iposi_pkg, iposi_front, iposi_queue and iposi_back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | to unit   | in_valid_i/in_stall_o | op_i, data_byte_i, last_i
//  out     | from unit | out_valid_o/out_stall_i| out_byte_o, end_of_header_o, header_words_o,
//          |           |                       | length_change_o, error_code_o
//
// One input item is taken per cycle while the 4-entry command queue has room.
// Output runs at one item per cycle while out_stall_i is low and the queue holds a command;
// the closing new-option byte expands to 1 + pad items (up to 4).
// The path from input to output passes the queue write and then the output register.
// Reset clears the parser state, queue pointers and output valid; no clearing pass.
// A stalled output holds its item; the queue keeps taking input until it is full.
module ip_option_strip_and_insert_unit #(
  parameter int unsigned MAX_OPTION_BYTES = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              end_of_header_o,
  output logic [3:0]        header_words_o,
  output logic signed [6:0] length_change_o,
  output logic [1:0]        error_code_o
);

  logic            accept;
  logic            push;
  iposi_pkg::cmd_t push_cmd;
  iposi_pkg::cmd_t head;
  logic            pop;
  logic            empty;
  logic            full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  iposi_front #(
    .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .data_byte_i(data_byte_i),
    .last_i     (last_i),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  iposi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (empty),
    .full_o    (full)
  );

  iposi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .end_of_header_o(end_of_header_o),
    .header_words_o (header_words_o),
    .length_change_o(length_change_o),
    .error_code_o   (error_code_o)
  );

endmodule

@@ src/iposi_checker.sv @@
// Port-level checks for the IPv4 option rewrite unit, bound to its top level.
// Depends only on the top level's ports.
module iposi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [7:0]        out_byte_o,
  input logic              end_of_header_o,
  input logic [3:0]        header_words_o,
  input logic signed [6:0] length_change_o,
  input logic [1:0]        error_code_o
);

  // summary fields only appear on the closing item
  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_header_o |->
      header_words_o == 4'd0 && length_change_o == 7'sd0 && error_code_o == 2'd0)
    else $error("summary fields set on a non-final item");

  a_words_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_header_o |-> header_words_o >= 4'd5)
    else $error("header length below 5 words");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_code_o != 2'd3)
    else $error("undefined error code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(end_of_header_o))
    else $error("stalled output item changed");

endmodule

bind ip_option_strip_and_insert_unit iposi_checker u_iposi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .end_of_header_o(end_of_header_o),
  .header_words_o (header_words_o),
  .length_change_o(length_change_o),
  .error_code_o   (error_code_o)
);

@@ tb/ip_option_strip_and_insert_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for ip_option_strip_and_insert_unit: streams option-area bytes with random idling
// and checks each rewritten byte against a scoreboard that predicts the rewrite.
// Depends on iposi_pkg and the unit's RTL.
module ip_option_strip_and_insert_unit_tb;

  localparam int MAX_OPT_BYTES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int RANDOM_ITEMS   = 75;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              end_of_header;
    logic [3:0]        header_words;
    logic signed [6:0] length_change;
    logic [1:0]        error_code;
  } hdr_byte_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last;
  } opt_item_t;

  class rewrite_scoreboard;
    logic [5:0] value_left;
    bit         want_length;
    bit         dropping;
    bit         stopped;
    logic [5:0] old_count;
    logic [5:0] new_count;
    logic [1:0] sticky_err;
    hdr_byte_t  expected_bytes[$];
    int         mismatches;

    function new();
      clear_header();
      mismatches = 0;
    endfunction

    function void clear_header();
      value_left  = '0;
      want_length = 0;
      dropping    = 0;
      stopped     = 0;
      old_count   = '0;
      new_count   = '0;
      sticky_err  = iposi_pkg::ERR_NONE;
    endfunction

    // first error wins
    function void flag(logic [1:0] code);
      if (sticky_err == iposi_pkg::ERR_NONE) sticky_err = code;
    endfunction

    function void emit_byte(logic [7:0] b);
      hdr_byte_t r;
      r = '0;
      r.out_byte = b;
      expected_bytes.push_back(r);
      if (new_count < iposi_pkg::CNT_MAX) new_count++;
      if (new_count > MAX_OPT_BYTES) flag(iposi_pkg::ERR_SIZE);
    endfunction

    function void stop_parse();
      stopped     = 1;
      want_length = 0;
      dropping    = 0;
      value_left  = '0;
    endfunction

    function void parse_original(logic [7:0] b, logic last);
      if (old_count < iposi_pkg::CNT_MAX) old_count++;
      if (old_count > MAX_OPT_BYTES) flag(iposi_pkg::ERR_SIZE);
      if (stopped) return;
      if (want_length) begin
        want_length = 0;
        if (b < 2 || b > MAX_OPT_BYTES) begin
          flag(iposi_pkg::ERR_LEN);
          stop_parse();
          return;
        end
        value_left = 6'(b - 8'd2);
        if (!dropping) emit_byte(b);
      end else if (value_left != 0) begin
        value_left--;
        if (!dropping) emit_byte(b);
      end else if (b == iposi_pkg::OPT_EOL) begin
        stop_parse();
        return;
      end else if (b != iposi_pkg::OPT_NOP) begin
        want_length = 1;
        dropping = (b == iposi_pkg::OPT_BSO || b == iposi_pkg::OPT_ESO ||
                    b == iposi_pkg::OPT_CIPSO);
        if (!dropping) emit_byte(b);
      end
      // run of original bytes ended inside an option
      if (last && (want_length || value_left != 0)) begin
        flag(iposi_pkg::ERR_LEN);
        stop_parse();
      end
    endfunction

    function void append_new(logic [7:0] b, logic last);
      int        total;
      int        pad;
      int        words;
      int        change;
      hdr_byte_t tail;
      emit_byte(b);
      if (!last) return;
      if (!stopped && (want_length || value_left != 0)) flag(iposi_pkg::ERR_LEN);
      total = new_count;
      pad = (4 - total % 4) % 4;
      repeat (pad) emit_byte(iposi_pkg::OPT_EOL);
      total += pad;
      if (total > MAX_OPT_BYTES) flag(iposi_pkg::ERR_SIZE);
      words = 5 + total / 4;
      if (words > 15) words = 15;
      change = total - int'(old_count);
      if (change > 63) change = 63;
      if (change < -64) change = -64;
      tail = expected_bytes.pop_back();
      tail.end_of_header = 1'b1;
      tail.header_words  = 4'(words);
      tail.length_change = 7'(change);
      tail.error_code    = sticky_err;
      expected_bytes.push_back(tail);
      clear_header();
    endfunction

    function void note_item(opt_item_t it);
      if (it.op) append_new(it.data_byte, it.last);
      else parse_original(it.data_byte, it.last);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(hdr_byte_t got);
      hdr_byte_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output item, actual byte %0d", $time, got.out_byte);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      compare("out_byte", want.out_byte, got.out_byte);
      compare("end_of_header", want.end_of_header, got.end_of_header);
      compare("header_words", want.header_words, got.header_words);
      compare("length_change", $signed(want.length_change), $signed(got.length_change));
      compare("error_code", want.error_code, got.error_code);
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              op_i        = 1'b0;
  logic [7:0]        data_byte_i = 8'd0;
  logic              last_i      = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        out_byte_o;
  logic              end_of_header_o;
  logic [3:0]        header_words_o;
  logic signed [6:0] length_change_o;
  logic [1:0]        error_code_o;

  rewrite_scoreboard sb;
  opt_item_t         stim_q[$];
  logic [7:0]        run_q[$];
  int                phase       = 0;
  int                hold_left   = 0;
  bit                hold_done   = 0;
  int                quiet_cycles = 0;
  hdr_byte_t         got_byte;

  ip_option_strip_and_insert_unit #(
    .MAX_OPTION_BYTES(MAX_OPT_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .end_of_header_o(end_of_header_o),
    .header_words_o (header_words_o),
    .length_change_o(length_change_o),
    .error_code_o   (error_code_o)
  );

  always #4 clk_i = ~clk_i;

  function void add_item(logic op, logic [7:0] b, logic last);
    opt_item_t it;
    it.op        = op;
    it.data_byte = b;
    it.last      = last;
    stim_q.push_back(it);
  endfunction

  function void flush_run(logic op, bit mark_last);
    foreach (run_q[k]) add_item(op, run_q[k], mark_last && (k == run_q.size() - 1));
    run_q.delete();
  endfunction

  function void push_option(bit secure);
    int         len;
    logic [7:0] kind;
    len = $urandom_range(2, 8);
    if (secure) begin
      case ($urandom_range(0, 2))
        0: kind = iposi_pkg::OPT_BSO;
        1: kind = iposi_pkg::OPT_ESO;
        default: kind = iposi_pkg::OPT_CIPSO;
      endcase
    end else begin
      kind = 8'($urandom_range(2, 255));
      if (kind == iposi_pkg::OPT_BSO || kind == iposi_pkg::OPT_ESO ||
          kind == iposi_pkg::OPT_CIPSO) kind = 8'd68;
    end
    run_q.push_back(kind);
    run_q.push_back(8'(len));
    repeat (len - 2) run_q.push_back(8'($urandom));
  endfunction

  function void add_random_header(bit oversize);
    int pick;
    int sub;
    pick = $urandom_range(0, 99);
    run_q.delete();
    if (oversize) begin
      // more than MAX_OPT_BYTES of passed-through options
      while (run_q.size() <= MAX_OPT_BYTES) push_option(0);
      flush_run(1'b0, 1);
      add_item(1'b1, 8'($urandom), 1'b1);
    end else if (pick < 70) begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0, 1: run_q.push_back(iposi_pkg::OPT_NOP);
          2, 3: push_option(1);
          9: begin
            run_q.push_back(iposi_pkg::OPT_EOL);
            run_q.push_back(8'($urandom));
          end
          default: push_option(0);
        endcase
      end
      flush_run(1'b0, 1);
      repeat ($urandom_range(1, 8)) run_q.push_back(8'($urandom));
      flush_run(1'b1, 1);
    end else if (pick < 85) begin
      // noise, mixed order
      repeat ($urandom_range(1, 10))
        add_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
      add_item(1'b1, 8'($urandom), 1'b1);
    end else begin
      push_option(0);
      sub = $urandom_range(0, 2);
      if (sub == 0)
        run_q[1] = $urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                        : 8'($urandom_range(MAX_OPT_BYTES + 1, 255));
      else
        void'(run_q.pop_back());
      // sub 2: original run never marked last, header closes mid-option
      flush_run(1'b0, sub != 2);
      repeat ($urandom_range(1, 4)) run_q.push_back(8'($urandom));
      flush_run(1'b1, 1);
    end
  endfunction

  // receiver: checks accepted items and drives stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_byte = {out_byte_o, end_of_header_o, header_words_o, length_change_o, error_code_o};
        sb.check_result(got_byte);
      end
      if (phase == 2 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < ((phase == 0) ? 72 : (phase == 1) ? 16 : 0));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n_directed;
    int third;
    int snd_idle;
    bit pause;
    sb = new();

    // NOP, dropped basic security, pass-through, EOL then ignored trailing byte
    add_item(1'b0, iposi_pkg::OPT_NOP, 1'b0);
    add_item(1'b0, iposi_pkg::OPT_BSO, 1'b0);
    add_item(1'b0, 8'd3, 1'b0);
    add_item(1'b0, 8'hAA, 1'b0);
    add_item(1'b0, 8'd7, 1'b0);
    add_item(1'b0, 8'd3, 1'b0);
    add_item(1'b0, 8'hFF, 1'b0);
    add_item(1'b0, iposi_pkg::OPT_EOL, 1'b0);
    add_item(1'b0, 8'h55, 1'b1);
    add_item(1'b1, 8'hFF, 1'b1);
    // length below 2
    add_item(1'b0, 8'd68, 1'b0);
    add_item(1'b0, 8'd1, 1'b1);
    add_item(1'b1, iposi_pkg::OPT_ESO, 1'b0);
    add_item(1'b1, iposi_pkg::OPT_EOL, 1'b1);
    // option cut short by last
    add_item(1'b0, 8'd7, 1'b0);
    add_item(1'b0, 8'd5, 1'b0);
    add_item(1'b0, 8'h01, 1'b1);
    add_item(1'b1, 8'h80, 1'b1);
    // length above max, later originals ignored
    add_item(1'b0, iposi_pkg::OPT_ESO, 1'b0);
    add_item(1'b0, 8'd41, 1'b0);
    add_item(1'b0, 8'h44, 1'b1);
    add_item(1'b1, iposi_pkg::OPT_CIPSO, 1'b1);
    // originals after new bytes, header closes awaiting a length
    add_item(1'b1, 8'h94, 1'b0);
    add_item(1'b0, iposi_pkg::OPT_CIPSO, 1'b0);
    add_item(1'b0, 8'd2, 1'b0);
    add_item(1'b0, 8'd68, 1'b0);
    add_item(1'b1, 8'h02, 1'b1);
    n_directed = stim_q.size();

    add_random_header(1);
    while (stim_q.size() - n_directed < RANDOM_ITEMS) add_random_header(0);
    third = stim_q.size() / 3;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_q[i]) begin
      if (i == third) phase = 1;
      snd_idle = (phase == 0) ? 16 : (phase == 1) ? 72 : 0;
      pause = (i == 2 * third);
      if (pause || $urandom_range(0, 99) < snd_idle) begin
        in_valid_i <= 1'b0;
        if (pause) begin
          // drain fully, then the receiver holds off while the sender keeps going
          do @(posedge clk_i); while (sb.pending() != 0);
          phase = 2;
        end else begin
          do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
        end
      end
      in_valid_i  <= 1'b1;
      op_i        <= stim_q[i].op;
      data_byte_i <= stim_q[i].data_byte;
      last_i      <= stim_q[i].last;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_item(stim_q[i]);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
